/* rtl/bir_pkg.sv */
// Shared types, constants and codes for the bilinear image resize block.
`default_nettype none
package bir_pkg;

  localparam int COORD_W    = 12;
  localparam int SCALE_W    = 26;
  localparam int SIZE_W     = 10;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int POS_FRAC   = 17;
  localparam int T_W        = COORD_W + 1 + SCALE_W;
  localparam int IP_W       = T_W - POS_FRAC;
  localparam int FRAC_MAX   = 20;
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam int MAX_SRC_WIDTH_DEF  = 512;
  localparam int MAX_SRC_HEIGHT_DEF = 512;
  localparam int FRAC_BITS_DEF      = 16;

  localparam logic [SIZE_W-1:0]  SRC_WIDTH_RST  = SIZE_W'(512);
  localparam logic [SIZE_W-1:0]  SRC_HEIGHT_RST = SIZE_W'(512);
  localparam logic [SCALE_W-1:0] SCALE_RST      = SCALE_W'(65536);

  typedef logic [PIX_W-1:0] pixel_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SRC_WIDTH  = 8'd0,
    REG_SRC_HEIGHT = 8'd1,
    REG_X_SCALE    = 8'd2,
    REG_Y_SCALE    = 8'd3
  } cfg_reg_t;

  // per-stage load enables: a scale multiply, b coordinate map, c store read,
  // d horizontal blend, e vertical blend / output
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
    logic e;
  } stage_en_t;

endpackage
`default_nettype wire

/* rtl/bir_if.sv */
// Channel interfaces: input items, result items and configuration writes.
`default_nettype none
interface bir_in_if;
  import bir_pkg::*;
  logic                    valid;
  logic                    ready;
  op_t                     op;
  logic [COORD_W-1:0]      row;
  logic [COORD_W-1:0]      col;
  logic [CH_W-1:0]         in_red;
  logic [CH_W-1:0]         in_green;
  logic [CH_W-1:0]         in_blue;
  modport source (output valid, op, row, col, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, op, row, col, in_red, in_green, in_blue, output ready);
endinterface

interface bir_out_if;
  import bir_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface bir_cfg_if;
  import bir_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface
`default_nettype wire

/* rtl/bir_coord.sv */
// One axis of the coordinate map: scale multiply, then clamp to neighbor indices and fraction.
`default_nettype none
module bir_coord #(
  parameter int MAX_SIZE  = bir_pkg::MAX_SRC_WIDTH_DEF,
  parameter int FRAC_BITS = bir_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  bir_pkg::stage_en_t               en,
  input  logic [bir_pkg::COORD_W-1:0]      dst,
  input  logic [bir_pkg::SCALE_W-1:0]      scale,
  input  logic [bir_pkg::SIZE_W-1:0]       size_cfg,
  output logic [$clog2(MAX_SIZE)-1:0]      lo,
  output logic [$clog2(MAX_SIZE)-1:0]      hi,
  output logic [FRAC_BITS-1:0]             frac
);
  import bir_pkg::*;

  localparam int IW = $clog2(MAX_SIZE);
  localparam logic [T_W-1:0]  HALF    = T_W'(1) << (POS_FRAC - 1);
  localparam logic [IP_W-1:0] MAX_EXT = IP_W'(MAX_SIZE);

  logic [T_W-1:0]       t_nxt, t_r, p;
  logic [IP_W-1:0]      ip, size_ext, eff, last;
  logic [FRAC_MAX-1:0]  fext;
  logic                 neg, at_edge;
  logic [IW-1:0]        lo_nxt, hi_nxt, lo_r, hi_r;
  logic [FRAC_BITS-1:0] frac_nxt, frac_r;

  // (2d+1)*scale, position in Q.17 plus one half
  always_comb begin
    t_nxt = T_W'({dst, 1'b1}) * T_W'(scale);
  end

  always_ff @(posedge clk) begin
    if (en.a) begin
      t_r <= t_nxt;
    end
  end

  always_comb begin
    neg      = t_r < HALF;
    p        = t_r - HALF;
    ip       = p[T_W-1:POS_FRAC];
    fext     = {p[POS_FRAC-1:0], (FRAC_MAX - POS_FRAC)'(0)};
    size_ext = IP_W'(size_cfg);
    if (size_cfg == '0) begin
      eff = IP_W'(1);
    end else if (size_ext > MAX_EXT) begin
      eff = MAX_EXT;
    end else begin
      eff = size_ext;
    end
    last    = eff - IP_W'(1);
    at_edge = ip >= last;
    if (neg) begin
      lo_nxt   = '0;
      hi_nxt   = '0;
      frac_nxt = '0;
    end else if (at_edge) begin
      lo_nxt   = IW'(last);
      hi_nxt   = IW'(last);
      frac_nxt = '0;
    end else begin
      lo_nxt   = IW'(ip);
      hi_nxt   = IW'(ip) + IW'(1);
      frac_nxt = fext[FRAC_MAX-1 -: FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en.b) begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      frac_r <= frac_nxt;
    end
  end

  assign lo   = lo_r;
  assign hi   = hi_r;
  assign frac = frac_r;

endmodule
`default_nettype wire

/* rtl/bir_store.sv */
// Source image store in four row/column parity banks; one access per bank per cycle.
`default_nettype none
module bir_store #(
  parameter int MAX_W = bir_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_H = bir_pkg::MAX_SRC_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic                       wr_en,
  input  logic [$clog2(MAX_H)-1:0]   wr_row,
  input  logic [$clog2(MAX_W)-1:0]   wr_col,
  input  bir_pkg::pixel_t            wr_data,
  input  logic [$clog2(MAX_H)-1:0]   y0,
  input  logic [$clog2(MAX_H)-1:0]   y1,
  input  logic [$clog2(MAX_W)-1:0]   x0,
  input  logic [$clog2(MAX_W)-1:0]   x1,
  output bir_pkg::pixel_t            pix_a,
  output bir_pkg::pixel_t            pix_b,
  output bir_pkg::pixel_t            pix_c,
  output bir_pkg::pixel_t            pix_d
);
  import bir_pkg::*;

  localparam int RB    = $clog2(MAX_H);
  localparam int CB    = $clog2(MAX_W);
  localparam int HRB   = (RB > 1) ? RB - 1 : 1;
  localparam int HCB   = (CB > 1) ? CB - 1 : 1;
  localparam int AW    = HRB + HCB;
  localparam int DEPTH = 1 << AW;

  function automatic logic [AW-1:0] bank_addr(input logic [RB-1:0] r, input logic [CB-1:0] c);
    return {HRB'(r >> 1), HCB'(c >> 1)};
  endfunction

  logic [AW-1:0] wr_addr;
  logic [1:0]    wr_bank;
  pixel_t        bank_q [4];
  logic          y0p_r, y1p_r, x0p_r, x1p_r;

  assign wr_addr = bank_addr(wr_row, wr_col);
  assign wr_bank = {wr_row[0], wr_col[0]};

  for (genvar k = 0; k < 4; k++) begin : g_bank
    localparam logic RP = 1'((k >> 1) & 1);
    localparam logic CP = 1'(k & 1);
    logic [AW-1:0] rd_addr;
    pixel_t        mem [DEPTH];
    pixel_t        q_r;

    // the neighbor row/column of this bank's parity
    assign rd_addr = bank_addr((y0[0] == RP) ? y0 : y1, (x0[0] == CP) ? x0 : x1);

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(k))) begin
        mem[wr_addr] <= wr_data;
      end else if (rd_en) begin
        q_r <= mem[rd_addr];
      end
    end

    assign bank_q[k] = q_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      y0p_r <= y0[0];
      y1p_r <= y1[0];
      x0p_r <= x0[0];
      x1p_r <= x1[0];
    end
  end

  assign pix_a = bank_q[{y0p_r, x0p_r}];
  assign pix_b = bank_q[{y0p_r, x1p_r}];
  assign pix_c = bank_q[{y1p_r, x0p_r}];
  assign pix_d = bank_q[{y1p_r, x1p_r}];

endmodule
`default_nettype wire

/* rtl/bir_blend.sv */
// Two-stage weighted blend per channel: horizontal, then vertical with truncation.
`default_nettype none
module bir_blend #(
  parameter int FRAC_BITS = bir_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  bir_pkg::stage_en_t         en,
  input  bir_pkg::pixel_t            pix_a,
  input  bir_pkg::pixel_t            pix_b,
  input  bir_pkg::pixel_t            pix_c,
  input  bir_pkg::pixel_t            pix_d,
  input  logic [FRAC_BITS-1:0]       fx,
  input  logic [FRAC_BITS-1:0]       fy,
  output logic [bir_pkg::CH_W-1:0]   red,
  output logic [bir_pkg::CH_W-1:0]   green,
  output logic [bir_pkg::CH_W-1:0]   blue
);
  import bir_pkg::*;

  localparam int WW = FRAC_BITS + 1;
  localparam int HW = CH_W + FRAC_BITS;
  localparam int VW = CH_W + 2 * FRAC_BITS;
  localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

  logic [WW-1:0]        wxl, wxh, wyl, wyh;
  logic [FRAC_BITS-1:0] fy_r;
  logic [CH_W-1:0]      ch_out [3];

  assign wxh = WW'(fx);
  assign wxl = ONE - wxh;
  assign wyh = WW'(fy_r);
  assign wyl = ONE - wyh;

  always_ff @(posedge clk) begin
    if (en.d) begin
      fy_r <= fy;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_ch
    localparam int SH = (2 - c) * CH_W;
    logic [HW-1:0]   top_nxt, bot_nxt, top_r, bot_r;
    logic [VW-1:0]   tot;
    logic [CH_W-1:0] ch_r;

    assign top_nxt = HW'(pix_a[SH +: CH_W]) * HW'(wxl) + HW'(pix_b[SH +: CH_W]) * HW'(wxh);
    assign bot_nxt = HW'(pix_c[SH +: CH_W]) * HW'(wxl) + HW'(pix_d[SH +: CH_W]) * HW'(wxh);

    always_ff @(posedge clk) begin
      if (en.d) begin
        top_r <= top_nxt;
        bot_r <= bot_nxt;
      end
    end

    assign tot = VW'(top_r) * VW'(wyl) + VW'(bot_r) * VW'(wyh);

    always_ff @(posedge clk) begin
      if (en.e) begin
        ch_r <= tot[VW-1 -: CH_W];
      end
    end

    assign ch_out[c] = ch_r;
  end

  assign red   = ch_out[0];
  assign green = ch_out[1];
  assign blue  = ch_out[2];

endmodule
`default_nettype wire

/* rtl/bilinear_image_resize.sv */
// Top level of the bilinear image resize block with half-pixel centers.
// Takes one item per cycle unless the output stalls, loads and queries mixed
// freely; a query gives one result, a load gives none and is visible to every
// later query. The five stages are: scale multiply, neighbor and fraction
// map, image store read, horizontal blend, vertical blend into the output
// register. Each stage holds while the next is full, so a stalled output
// only backs up as far as the bubbles allow. The four neighbors of a query
// come from four single-port banks split by row and column parity, so each
// bank serves one access a cycle. The store is not cleared at reset;
// querying a pixel that was never loaded gives unspecified channel values.
`default_nettype none
module bilinear_image_resize #(
  parameter int MAX_SRC_WIDTH  = bir_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = bir_pkg::MAX_SRC_HEIGHT_DEF,
  parameter int FRAC_BITS      = bir_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bir_in_if.sink       in_ch,
  bir_out_if.source    out_ch,
  bir_cfg_if.sink      cfg_ch
);
  import bir_pkg::*;

  localparam int RB = $clog2(MAX_SRC_HEIGHT);
  localparam int CB = $clog2(MAX_SRC_WIDTH);

  logic [SIZE_W-1:0]  src_width_r, src_height_r;
  logic [SCALE_W-1:0] x_scale_r, y_scale_r;

  stage_en_t en;
  logic      va_r, vb_r, vc_r, vd_r, ve_r;

  op_t                op_a_r, op_b_r;
  logic [COORD_W-1:0] row_a_r, col_a_r;
  pixel_t             rgb_a_r, rgb_b_r;
  logic               wr_ok_nxt, wr_ok_b_r;
  logic [RB-1:0]      row_b_r;
  logic [CB-1:0]      col_b_r;

  logic [CB-1:0]        x0_b, x1_b;
  logic [RB-1:0]        y0_b, y1_b;
  logic [FRAC_BITS-1:0] fx_b, fy_b, fx_c_r, fy_c_r;
  pixel_t               pix_a, pix_b, pix_c, pix_d;
  logic [CH_W-1:0]      red_e, green_e, blue_e;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_WIDTH_RST;
      src_height_r <= SRC_HEIGHT_RST;
      x_scale_r    <= SCALE_RST;
      y_scale_r    <= SCALE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.addr))
        REG_SRC_WIDTH:  src_width_r  <= SIZE_W'(cfg_ch.data);
        REG_SRC_HEIGHT: src_height_r <= SIZE_W'(cfg_ch.data);
        REG_X_SCALE:    x_scale_r    <= SCALE_W'(cfg_ch.data);
        REG_Y_SCALE:    y_scale_r    <= SCALE_W'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // stage flow control
  always_comb begin
    en.e = !ve_r || out_ch.ready;
    en.d = !vd_r || en.e;
    en.c = !vc_r || en.d;
    en.b = !vb_r || en.c;
    en.a = !va_r || en.b;
  end

  assign in_ch.ready = en.a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      if (en.a) begin
        va_r <= in_ch.valid;
      end
      if (en.b) begin
        vb_r <= va_r;
      end
      if (en.c) begin
        vc_r <= vb_r && (op_b_r == OP_QUERY);
      end
      if (en.d) begin
        vd_r <= vc_r;
      end
      if (en.e) begin
        ve_r <= vd_r;
      end
    end
  end

  // load path payload
  assign wr_ok_nxt = (op_a_r == OP_LOAD)
                  && ({1'b0, row_a_r} < (COORD_W + 1)'(MAX_SRC_HEIGHT))
                  && ({1'b0, col_a_r} < (COORD_W + 1)'(MAX_SRC_WIDTH));

  always_ff @(posedge clk) begin
    if (en.a) begin
      op_a_r  <= in_ch.op;
      row_a_r <= in_ch.row;
      col_a_r <= in_ch.col;
      rgb_a_r <= {in_ch.in_red, in_ch.in_green, in_ch.in_blue};
    end
    if (en.b) begin
      op_b_r    <= op_a_r;
      wr_ok_b_r <= wr_ok_nxt;
      row_b_r   <= RB'(row_a_r);
      col_b_r   <= CB'(col_a_r);
      rgb_b_r   <= rgb_a_r;
    end
    if (en.c) begin
      fx_c_r <= fx_b;
      fy_c_r <= fy_b;
    end
  end

  bir_coord #(
    .MAX_SIZE  (MAX_SRC_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_coord_x (
    .clk      (clk),
    .en       (en),
    .dst      (in_ch.col),
    .scale    (x_scale_r),
    .size_cfg (src_width_r),
    .lo       (x0_b),
    .hi       (x1_b),
    .frac     (fx_b)
  );

  bir_coord #(
    .MAX_SIZE  (MAX_SRC_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_coord_y (
    .clk      (clk),
    .en       (en),
    .dst      (in_ch.row),
    .scale    (y_scale_r),
    .size_cfg (src_height_r),
    .lo       (y0_b),
    .hi       (y1_b),
    .frac     (fy_b)
  );

  bir_store #(
    .MAX_W (MAX_SRC_WIDTH),
    .MAX_H (MAX_SRC_HEIGHT)
  ) u_store (
    .clk     (clk),
    .rd_en   (en.c),
    .wr_en   (en.c && vb_r && wr_ok_b_r),
    .wr_row  (row_b_r),
    .wr_col  (col_b_r),
    .wr_data (rgb_b_r),
    .y0      (y0_b),
    .y1      (y1_b),
    .x0      (x0_b),
    .x1      (x1_b),
    .pix_a   (pix_a),
    .pix_b   (pix_b),
    .pix_c   (pix_c),
    .pix_d   (pix_d)
  );

  bir_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_blend (
    .clk   (clk),
    .en    (en),
    .pix_a (pix_a),
    .pix_b (pix_b),
    .pix_c (pix_c),
    .pix_d (pix_d),
    .fx    (fx_c_r),
    .fy    (fy_c_r),
    .red   (red_e),
    .green (green_e),
    .blue  (blue_e)
  );

  assign out_ch.valid     = ve_r;
  assign out_ch.out_red   = red_e;
  assign out_ch.out_green = green_e;
  assign out_ch.out_blue  = blue_e;

  // loads drop out after the store stage
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    en.c && vb_r && (op_b_r == OP_LOAD) |=> !vc_r)
    else $error("load item passed the store stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r && !en.d |=> vc_r)
    else $error("stalled item lost in read stage");

  a_x_neighbors: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && (fx_b != '0) |-> (x1_b == x0_b + CB'(1)))
    else $error("nonzero x fraction without adjacent columns");

  a_y_neighbors: assert property (@(posedge clk) disable iff (!rst_n)
    vb_r && (fy_b != '0) |-> (y1_b == y0_b + RB'(1)))
    else $error("nonzero y fraction without adjacent rows");

endmodule
`default_nettype wire
